// ===== rtl/rfir_pkg.sv =====
// ----------------------------------------------------------------------------
// rfir_pkg
// Shared widths, register indexes and types of the row FIR filter.
// ----------------------------------------------------------------------------
package rfir_pkg;

  // Kernel and pixel geometry.
  localparam int MAX_TAPS  = 7;
  localparam int MAX_WIDTH = 4096;
  localparam int FRAC_BITS = 12;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int TAP_W   = 3;
  localparam int COL_W   = 12;
  localparam int FILL_W  = $clog2(MAX_WIDTH) + 1;
  localparam int PROD_W  = PIX_W + COEF_W;
  localparam int PSUM_W  = PROD_W + $clog2(MAX_TAPS);

  // Control pipeline: one stage for the window, one for the products and
  // one per cell for the running sum.
  localparam int PIPE_DEPTH = MAX_TAPS + 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd1;

  // Reset values of the kernel (a single tap of 1.0).
  localparam logic [TAP_W-1:0]         TAP_COUNT_RESET = 3'd1;
  localparam logic signed [COEF_W-1:0] COEF0_RESET     = 16'sd4096;

  // Per-item control that travels alongside the sum.
  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
  } pipe_ctrl_t;

endpackage

// ===== rtl/rfir_cell.sv =====
// ----------------------------------------------------------------------------
// rfir_cell
// One filter cell: a window pixel register, one product and a running sum.
// ----------------------------------------------------------------------------
module rfir_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                shift_en,
  input  logic                                adv,
  input  logic [rfir_pkg::PIX_W-1:0]          pix_prev,
  input  logic [rfir_pkg::PIX_W-1:0]          pix_tap,
  input  logic signed [rfir_pkg::COEF_W-1:0]  coef,
  input  logic signed [rfir_pkg::PSUM_W-1:0]  psum_prev,
  output logic [rfir_pkg::PIX_W-1:0]          pix_win,
  output logic signed [rfir_pkg::PSUM_W-1:0]  psum
);
  import rfir_pkg::*;

  logic [PIX_W-1:0]              win_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PSUM_W-1:0]      psum_r;
  logic signed [PIX_W+COEF_W:0]  prod_full;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [PSUM_W-1:0]      psum_nxt;

  // The window pixel moves one cell down with every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (shift_en) begin
      win_r <= pix_prev;
    end
  end

  // Unsigned pixel times signed coefficient; the result fits PROD_W bits.
  assign prod_full = $signed({1'b0, pix_tap}) * coef;
  assign prod_nxt  = prod_full[PROD_W-1:0];

  // Add this cell's product to the sum handed over by the previous cell.
  assign psum_nxt = psum_prev + {{(PSUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      psum_r <= psum_nxt;
    end
  end

  assign pix_win = win_r;
  assign psum    = psum_r;

endmodule

// ===== rtl/rfir_out.sv =====
// ----------------------------------------------------------------------------
// rfir_out
// Rounds the exact sum to nearest-even, clamps to 0..255 and holds the result.
// ----------------------------------------------------------------------------
module rfir_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  rfir_pkg::pipe_ctrl_t               ctrl,
  input  logic signed [rfir_pkg::PSUM_W-1:0] acc,
  output logic                               out_valid,
  output logic [rfir_pkg::PIX_W-1:0]         pixel,
  output logic [rfir_pkg::COL_W-1:0]         column
);
  import rfir_pkg::*;

  localparam int Q_W = PSUM_W - 1 - FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [Q_W:0] PIX_MAX = (Q_W+1)'((1 << PIX_W) - 1);

  logic                 valid_r;
  logic [PIX_W-1:0]     pixel_r;
  logic [COL_W-1:0]     column_r;
  logic [Q_W-1:0]       quot;
  logic [FRAC_BITS-1:0] rem;
  logic                 round_up;
  logic [Q_W:0]         rounded;
  logic [PIX_W-1:0]     pixel_nxt;

  // Split the magnitude into integer and fraction, round ties to even.
  assign quot     = acc[PSUM_W-2:FRAC_BITS];
  assign rem      = acc[FRAC_BITS-1:0];
  assign round_up = (rem > HALF) || ((rem == HALF) && quot[0]);
  assign rounded  = {1'b0, quot} + {{Q_W{1'b0}}, round_up};

  // Non-positive sums give zero, large ones saturate.
  always_comb begin
    if (acc[PSUM_W-1] || (acc == '0)) begin
      pixel_nxt = '0;
    end else if (rounded > PIX_MAX) begin
      pixel_nxt = PIX_MAX[PIX_W-1:0];
    end else begin
      pixel_nxt = rounded[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= ctrl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_r  <= pixel_nxt;
      column_r <= ctrl.col;
    end
  end

  assign out_valid = valid_r;
  assign pixel     = pixel_r;
  assign column    = column_r;

endmodule

// ===== rtl/row_fir_u8_saturating.sv =====
// ----------------------------------------------------------------------------
// row_fir_u8_saturating
// Horizontal FIR over a pixel stream, built as a chain of tap cells.
// ----------------------------------------------------------------------------
// Path: a result passes the window stage, the product stage, seven sum
// cells in a chain and the output register.
// Throughput: one pixel per cycle; the whole pipeline holds only while the
// output register is full and out_ready is low.
// Reset: synchronous, active low; clears the row fill count, the window, the
// pipeline valid bits, and loads tap_count = 1, coef_0 = 1.0, other taps 0.
module row_fir_u8_saturating (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rfir_pkg::PIX_W-1:0]             in_pixel_in,
  input  logic                                   in_row_start,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rfir_pkg::PIX_W-1:0]             out_pixel_out,
  output logic [rfir_pkg::COL_W-1:0]             out_column,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rfir_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rfir_pkg::COEF_W-1:0]            cfg_data
);
  import rfir_pkg::*;

  logic                       adv;
  logic                       accept;
  logic [TAP_W-1:0]           tap_count_r;
  logic signed [COEF_W-1:0]   coef_r [MAX_TAPS];
  logic [TAP_W-1:0]           tap_eff;
  logic signed [COEF_W-1:0]   cell_coef [MAX_TAPS];
  logic [FILL_W-1:0]          fill_r;
  logic [FILL_W-1:0]          fill_nxt;
  logic [FILL_W-1:0]          fill_base;
  logic [FILL_W-1:0]          fill_inc;
  logic                       room;
  logic                       produce;
  pipe_ctrl_t                 stage_nxt;
  pipe_ctrl_t                 pipe_r [PIPE_DEPTH];
  logic [PIX_W-1:0]           win [MAX_TAPS];
  logic [PIX_W-1:0]           tap_pix [MAX_TAPS];
  logic signed [PSUM_W-1:0]   psum [MAX_TAPS];

  // The pipeline moves unless the output register is full and out_ready low.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef_r[i] <= '0;
      end
      coef_r[0] <= COEF0_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAP_COUNT: begin
          tap_count_r <= cfg_data[TAP_W-1:0];
        end
        default: begin
          coef_r[TAP_W'(cfg_index - REG_COEF_0)] <= $signed(cfg_data);
        end
      endcase
    end
  end

  // A tap count of zero behaves as one.
  assign tap_eff = (tap_count_r == '0) ? TAP_W'(1) : tap_count_r;

  // Cell k holds the pixel of age k, which meets coefficient taps-1-k.
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      if (TAP_W'(k) < tap_eff) begin
        cell_coef[k] = coef_r[TAP_W'(tap_eff - TAP_W'(k) - TAP_W'(1))];
      end else begin
        cell_coef[k] = '0;
      end
    end
  end

  // Row fill count: cleared by row start, saturates at the maximum width.
  assign fill_base = in_row_start ? '0 : fill_r;
  assign room      = fill_base < FILL_W'(MAX_WIDTH);
  assign fill_inc  = fill_base + FILL_W'(1);
  assign produce   = room && (fill_inc >= FILL_W'(tap_eff));

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = room ? fill_inc : fill_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Control pipeline that tracks each beat through the cell chain.
  assign stage_nxt.vld = accept && produce;
  assign stage_nxt.col = COL_W'(fill_inc - FILL_W'(tap_eff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < PIPE_DEPTH; j++) begin
        pipe_r[j] <= '0;
      end
    end else if (adv) begin
      pipe_r[0] <= stage_nxt;
      for (int j = 1; j < PIPE_DEPTH; j++) begin
        pipe_r[j] <= pipe_r[j-1];
      end
    end
  end

  // Chain of cells; cell k sees its window pixel delayed by k stages so it
  // meets the running sum of the same beat.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_nodly
      assign tap_pix[k] = win[k];
    end else begin : g_dly
      logic [PIX_W-1:0] dly_r [k];

      always_ff @(posedge clk) begin
        if (adv) begin
          dly_r[0] <= win[k];
          for (int j = 1; j < k; j++) begin
            dly_r[j] <= dly_r[j-1];
          end
        end
      end

      assign tap_pix[k] = dly_r[k-1];
    end

    rfir_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (accept),
      .adv       (adv),
      .pix_prev  ((k == 0) ? in_pixel_in : win[(k == 0) ? 0 : k-1]),
      .pix_tap   (tap_pix[k]),
      .coef      (cell_coef[k]),
      .psum_prev ((k == 0) ? PSUM_W'(0) : psum[(k == 0) ? 0 : k-1]),
      .pix_win   (win[k]),
      .psum      (psum[k])
    );
  end

  // Rounding, clamping and the output register.
  rfir_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctrl      (pipe_r[PIPE_DEPTH-1]),
    .acc       (psum[MAX_TAPS-1]),
    .out_valid (out_valid),
    .pixel     (out_pixel_out),
    .column    (out_column)
  );

`ifndef SYNTHESIS
  // The fill count never passes the maximum row width.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_WIDTH))
    else $error("row fill count above maximum width");

  // A producing beat in the first stage has column = fill - taps.
  a_col_match: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_r[0].vld |-> (fill_r == FILL_W'(pipe_r[0].col) + FILL_W'(tap_eff)))
    else $error("output column does not match the row fill count");

  // While the pipeline holds, the fill count must not move.
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> (fill_r == $past(fill_r)))
    else $error("fill count changed during a stall");
`endif

endmodule

// ===== test/tb_row_fir_u8_saturating.sv =====
// ----------------------------------------------------------------------------
// tb_row_fir_u8_saturating
// Self-checking bench for the row FIR filter. Pixels go in as beats with
// random bursts and gaps, and a bit-exact filter model in the bench predicts
// each filtered pixel and its column. A checker pops one prediction per
// output beat and compares both fields. The receiver stalls on its own
// pattern. Directed tests cover the reset kernel, rounding ties, saturation,
// a zero tap count and row restarts. A long receiver hold-off is also
// exercised, followed by random kernels over random rows.
// ----------------------------------------------------------------------------
module tb_row_fir_u8_saturating;
  timeunit 1ns;
  timeprecision 1ps;

  import rfir_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;

  typedef logic [MAX_TAPS-1:0][COEF_W-1:0] kernel_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
  } fir_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 in_row_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic [COL_W-1:0]     out_column;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TAP_COUNT;
  logic [COEF_W-1:0]    cfg_data = '0;

  // Filter model state: shadow registers, pixel window and row fill count.
  logic [TAP_W-1:0]         tap_reg;
  logic signed [COEF_W-1:0] coef_reg [MAX_TAPS];
  logic [PIX_W-1:0]         win_px [MAX_TAPS];
  logic [FILL_W-1:0]        row_fill;

  fir_result_t filtered_q [$];
  fir_result_t want;
  int          bad_results = 0;
  int          burst_left = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;

  row_fir_u8_saturating dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .in_row_start  (in_row_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_column    (out_column),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run a generous fixed time at most.
  initial begin
    #5_000_000;
    $display("row_fir_u8_saturating: mismatch");
    $finish;
  end

  // Shift one accepted pixel through the model and queue the filtered
  // pixel it completes, if any.
  task automatic filter_pixel(input logic [PIX_W-1:0] px, input logic rs);
    int          taps;
    int          k;
    longint      acc;
    longint      q;
    longint      rem;
    fir_result_t res;
    taps = (tap_reg == '0) ? 1 : int'(tap_reg);
    if (rs) begin
      row_fill = '0;
    end
    for (k = MAX_TAPS - 1; k > 0; k--) begin
      win_px[k] = win_px[k-1];
    end
    win_px[0] = px;
    if (row_fill < MAX_WIDTH) begin
      row_fill = row_fill + 1'b1;
      if (row_fill >= taps) begin
        acc = 0;
        for (k = 0; k < taps; k++) begin
          acc += longint'(win_px[taps-1-k]) * longint'(coef_reg[k]);
        end
        // Round to nearest with ties to even, then clamp to a byte.
        if (acc <= 0) begin
          q = 0;
        end else begin
          q = acc >>> FRAC_BITS;
          rem = acc & ((longint'(1) << FRAC_BITS) - 1);
          if (rem > (longint'(1) << (FRAC_BITS - 1)) ||
              (rem == (longint'(1) << (FRAC_BITS - 1)) && q[0])) begin
            q++;
          end
          if (q > 255) begin
            q = 255;
          end
        end
        res.pix = PIX_W'(q);
        res.col = COL_W'(int'(row_fill) - taps);
        filtered_q.push_back(res);
      end
    end
  endtask

  // Offer one pixel beat, with a random gap at the start of each burst.
  task automatic send_beat(input logic [PIX_W-1:0] px, input logic rs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_pixel_in  <= px;
    in_row_start <= rs;
    do @(posedge clk); while (!in_ready);
    filter_pixel(px, rs);
  endtask

  // Stop sending and wait until every queued result has come out, then let
  // the pipeline run empty for pixels that make no result.
  task automatic settle(input int limit);
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (filtered_q.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the tap count and all seven coefficients on an idle block.
  task automatic set_kernel(input logic [TAP_W-1:0] taps, input kernel_t k);
    int i;
    settle(DRAIN_LIMIT);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TAP_COUNT;
    // Bits above the tap count field carry noise and must be ignored.
    cfg_data  <= {13'($urandom), taps};
    do @(posedge clk); while (!cfg_ready);
    tap_reg = taps;
    for (i = 0; i < MAX_TAPS; i++) begin
      cfg_index <= REG_COEF_0 + CFG_IDX_W'(i);
      cfg_data  <= k[i];
      do @(posedge clk); while (!cfg_ready);
      coef_reg[i] = k[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] any_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Kernels of three flavors: raw 16-bit noise, values spread around a unit
  // gain, and the coefficient extremes.
  function automatic kernel_t pick_kernel(input int flavor, input logic [TAP_W-1:0] taps);
    kernel_t k;
    int      t;
    int      i;
    t = (taps == '0) ? 1 : int'(taps);
    for (i = 0; i < MAX_TAPS; i++) begin
      case (flavor)
        0:       k[i] = COEF_W'($urandom);
        1:       k[i] = COEF_W'(int'($urandom_range(0, 12288 / t)) - 2048 / t);
        default: begin
          case ($urandom_range(0, 2))
            0:       k[i] = 16'h7FFF;
            1:       k[i] = 16'h8000;
            default: k[i] = '0;
          endcase
        end
      endcase
    end
    return k;
  endfunction

  // Output checker and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        if (bad_results < 10) begin
          $display("%0t: unexpected result pixel=%0d column=%0d", $realtime,
                   out_pixel_out, out_column);
        end
        bad_results++;
      end else begin
        want = filtered_q.pop_front();
        if (out_pixel_out !== want.pix || out_column !== want.col) begin
          if (bad_results < 10) begin
            $display("%0t: expected pixel=%0d column=%0d, got pixel=%0d column=%0d",
                     $realtime, want.pix, want.col, out_pixel_out, out_column);
          end
          bad_results++;
        end
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Reset kernel is a single tap of 1.0, and pixels before any row start
  // count as a row starting at column 0.
  task automatic test_default_kernel();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h5A, 1'b0);
  endtask

  // A gain of one half puts every odd pixel exactly on a rounding tie.
  task automatic test_round_ties();
    kernel_t k;
    k = '0;
    k[0] = 16'sd2048;
    set_kernel(3'd1, k);
    send_beat(8'd1, 1'b1);
    send_beat(8'd3, 1'b0);
    send_beat(8'd5, 1'b0);
    send_beat(8'd255, 1'b0);
  endtask

  // Seven taps at the largest and the most negative coefficient.
  task automatic test_saturation();
    int i;
    set_kernel(3'd7, {MAX_TAPS{16'h7FFF}});
    for (i = 0; i < 8; i++) begin
      send_beat(8'hFF, i == 0);
    end
    set_kernel(3'd7, {MAX_TAPS{16'h8000}});
    for (i = 0; i < 8; i++) begin
      send_beat(8'hFF, i == 0);
    end
  endtask

  // A tap count of zero must act as a single tap.
  task automatic test_tap_count_zero();
    kernel_t k;
    k = pick_kernel(0, 3'd7);
    k[0] = 16'sd4096;
    set_kernel(3'd0, k);
    send_beat(8'd17, 1'b1);
    send_beat(8'd200, 1'b0);
  endtask

  // Row starts clear the fill count; old pixels in the window are not used.
  task automatic test_row_restart();
    kernel_t k;
    k = '0;
    k[0] = 16'sd4096;
    k[1] = 16'sd8192;
    k[2] = -16'sd4096;
    set_kernel(3'd3, k);
    send_beat(8'd90, 1'b1);
    send_beat(8'd40, 1'b0);
    send_beat(8'd250, 1'b1);
    send_beat(8'd7, 1'b1);
    send_beat(8'd60, 1'b0);
    send_beat(8'd61, 1'b0);
    send_beat(8'd0, 1'b0);
  endtask

  // Hold the output off for a long stretch while pixels keep coming, so the
  // pipeline fills and back-pressures its input.
  task automatic test_input_stall();
    int i;
    set_kernel(3'd5, pick_kernel(1, 3'd5));
    hold_request = 300;
    for (i = 0; i < 60; i++) begin
      send_beat(any_pixel(), i == 0);
    end
  endtask

  // Random rows under several kernels; most rows are well formed, a few get
  // a stray row start in the middle.
  task automatic test_random_rows();
    logic [TAP_W-1:0] taps;
    int               phase;
    int               i;
    int               row_left;
    logic             rs;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       taps = 3'd7;
        1:       taps = 3'd1;
        2:       taps = 3'd0;
        default: taps = TAP_W'($urandom);
      endcase
      set_kernel(taps, pick_kernel(phase % 3, taps));
      row_left = 0;
      for (i = 0; i < 110; i++) begin
        if (row_left == 0) begin
          row_left = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 20)
                                                 : $urandom_range(20, 120);
          rs = 1'b1;
        end else begin
          rs = ($urandom_range(0, 24) == 0);
        end
        row_left--;
        send_beat(any_pixel(), rs);
        // Now and then let the output catch up completely.
        if ($urandom_range(0, 99) == 0) begin
          settle(DRAIN_LIMIT);
        end
      end
    end
  endtask

  initial begin
    int i;
    tap_reg = TAP_COUNT_RESET;
    for (i = 0; i < MAX_TAPS; i++) begin
      coef_reg[i] = '0;
      win_px[i] = '0;
    end
    coef_reg[0] = COEF0_RESET;
    row_fill = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_kernel();
    test_round_ties();
    test_saturation();
    test_tap_count_zero();
    test_row_restart();
    test_input_stall();
    test_random_rows();

    settle(DRAIN_LIMIT);
    if (bad_results == 0 && filtered_q.size() == 0) begin
      $display("row_fir_u8_saturating: match");
    end else begin
      $display("row_fir_u8_saturating: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rfir_pkg.sv
rtl/rfir_cell.sv
rtl/rfir_out.sv
rtl/row_fir_u8_saturating.sv
test/tb_row_fir_u8_saturating.sv
